### rtl/core/a85_pkg.sv
// ----------------------------------------------------------------------------
// a85_pkg: shared types and constants for the ASCII85 stream decoder
// Character codes, the decoded word record and the padding multiplier table.
// ----------------------------------------------------------------------------
`default_nettype none

package a85_pkg;

    localparam logic [7:0] C_Z       = 8'h7A;  // 'z'
    localparam logic [7:0] C_TILDE   = 8'h7E;  // '~'
    localparam logic [7:0] C_FIRST   = 8'h21;  // '!'
    localparam logic [7:0] C_LASTDIG = 8'h75;  // 'u'
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_DEL     = 8'h7F;

    localparam logic [31:0] BASE     = 32'd85;
    localparam logic [2:0]  GROUP    = 3'd5;
    localparam logic [2:0]  WORD_LEN = 3'd4;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // One decoded word waiting to be sent out, byte by byte.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;  // 1 to 4
        logic        err;     // a single error result instead of bytes
    } t_burst;

    typedef struct packed {
        logic   push;
        t_burst rec;
    } t_push;

    // 85 to the power k, for k padding digits of 84. Padding k digits of 84
    // onto acc gives acc * 85^k + (85^k - 1).
    function automatic logic [31:0] pow85(input logic [2:0] k);
        logic [31:0] p;
        unique case (k)
            3'd1:    p = 32'd85;
            3'd2:    p = 32'd7225;
            3'd3:    p = 32'd614125;
            3'd4:    p = 32'd52200625;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/core/a85_if.sv
// ----------------------------------------------------------------------------
// a85_if: stream channels of the ASCII85 decoder
// Valid/ready channels for encoded text words in and decoded result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface a85_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_byte;

    modport source (output valid, output kind, output in_byte, input ready);
    modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface a85_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       status;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid,
                    output status, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input status, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/a85_outq.sv
// ----------------------------------------------------------------------------
// a85_outq: decoded word queue and byte serialiser
// Holds up to two decoded words and sends them out one byte per word handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module a85_outq
    import a85_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_push       i_push,
    output logic        o_full,
    a85_out_if.source   o_out
);

    t_burst      r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_cnt, n_cnt;
    logic [1:0]  r_idx, n_idx;

    t_burst      head;
    logic        take;
    logic        pop;
    logic        is_last;
    logic [7:0]  sel_byte;

    assign head    = r_mem[r_rd_ptr];
    assign o_full  = (r_cnt == 2'd2);
    assign is_last = ({1'b0, r_idx} == (head.nbytes - 3'd1));
    assign take    = o_out.valid && o_out.ready;
    assign pop     = take && is_last;

    always_comb begin
        unique case (r_idx)
            2'd0:    sel_byte = head.word[31:24];
            2'd1:    sel_byte = head.word[23:16];
            2'd2:    sel_byte = head.word[15:8];
            default: sel_byte = head.word[7:0];
        endcase
    end

    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.out_byte   = sel_byte;
    assign o_out.byte_valid = !head.err;
    assign o_out.status     = head.err;
    assign o_out.last       = is_last;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        if (i_push.push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (pop) begin
            n_rd_ptr = !r_rd_ptr;
            n_idx    = 2'd0;
        end else if (take) begin
            n_idx = r_idx + 2'd1;
        end
        n_cnt = r_cnt + {1'b0, i_push.push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
            r_idx    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ascii85_stream_decoder.sv
// ----------------------------------------------------------------------------
// ascii85_stream_decoder: ASCII85 text to binary stream decoder
// Folds base-85 digits into 32-bit words and emits their bytes in order.
// ----------------------------------------------------------------------------
// Usage:
// i_in carries one text word per handshake (kind 0, in_byte) or an end word
// (kind 1) that flushes a partial group and returns the decoder to reset.
// o_out carries one result per handshake: a decoded byte, or a single error
// result (byte_valid 0, status 1). last marks the final result of an input.
// Each input word is decoded in the cycle it is accepted; when the queue is
// empty its first result is on o_out in the next cycle. A group of five
// digits, a 'z' or a flush gives up to four results, sent one per cycle
// while the receiver is ready, from a two-entry word queue.
// Input is taken every cycle while the queue has a free entry, so one input
// word per cycle is sustained while results average one per input; bursts of
// four bytes are limited by the one-byte-per-cycle output.
// The decode step is a single 32-bit multiply-add (by 85, or by the padding
// power of 85 on a flush) between the accumulator and the queue.
// Reset clears the accumulator, digit count, flags and queue.
// When the receiver stalls, results wait in the queue and i_in.ready falls
// once both entries are held.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii85_stream_decoder
    import a85_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    a85_in_if.sink      i_in,
    a85_out_if.source   o_out
);

    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_term, n_term;
    logic        r_failed, n_failed;

    logic        q_full;
    logic        accept;
    t_push       push;
    logic [7:0]  c;
    logic [31:0] mul_m;
    logic [31:0] add_a;
    logic [31:0] prod_full;
    logic [31:0] prod;

    assign i_in.ready = !q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign c          = i_in.in_byte;

    // Shared multiply-add: a digit step, or the padding of a partial group.
    always_comb begin
        if (i_in.kind == KIND_END) begin
            mul_m = pow85(GROUP - r_cnt);
            add_a = mul_m - 32'd1;
        end else begin
            mul_m = BASE;
            add_a = {24'd0, c - C_FIRST};
        end
    end

    // The accumulator wraps modulo 2^32, so only the low half is kept.
    assign prod_full = r_acc * mul_m;
    assign prod      = prod_full + add_a;

    always_comb begin
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_term   = r_term;
        n_failed = r_failed;
        push     = '0;
        if (accept) begin
            priority if (i_in.kind == KIND_END) begin
                if (!r_failed && r_cnt >= 3'd2 && r_cnt <= WORD_LEN) begin
                    push.push       = 1'b1;
                    push.rec.word   = prod;
                    push.rec.nbytes = r_cnt - 3'd1;
                end
                n_acc    = '0;
                n_cnt    = '0;
                n_term   = 1'b0;
                n_failed = 1'b0;
            end else if (r_term || r_failed) begin
                // Bytes after the terminator or an error are dropped.
            end else if (c == C_Z && r_cnt == 3'd0) begin
                push.push       = 1'b1;
                push.rec.nbytes = WORD_LEN;
            end else if (c == C_TILDE) begin
                n_term = 1'b1;
            end else if (c <= C_SPACE || c == C_DEL) begin
                // Whitespace is skipped.
            end else if (c > C_LASTDIG) begin
                n_failed        = 1'b1;
                push.push       = 1'b1;
                push.rec.nbytes = 3'd1;
                push.rec.err    = 1'b1;
            end else begin
                if (r_cnt == WORD_LEN) begin
                    push.push       = 1'b1;
                    push.rec.word   = prod;
                    push.rec.nbytes = WORD_LEN;
                    n_acc           = '0;
                    n_cnt           = '0;
                end else begin
                    n_acc = prod;
                    n_cnt = r_cnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_cnt    <= '0;
            r_term   <= 1'b0;
            r_failed <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_term   <= n_term;
            r_failed <= n_failed;
        end
    end

    a85_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.kind == KIND_END
        |=> r_cnt == 3'd0 && !r_term && !r_failed && r_acc == 32'd0)
        else $error("end of stream did not return the decoder to reset");

    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed && !(accept && i_in.kind == KIND_END) |=> r_failed)
        else $error("error state left without an end of stream");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && push.push && push.rec.err |=> r_failed && r_cnt == $past(r_cnt))
        else $error("error result without the error state");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status |-> o_out.last && !o_out.byte_valid)
        else $error("error result not a lone final result");
`endif

endmodule

`default_nettype wire
